[rtl/tsrr_pkg.sv]
// ---------------------------------------------------------------------------
// Task slot table package
// Sizes, request codes and status codes of the round-robin task slot table.
// ---------------------------------------------------------------------------
`default_nettype none

package tsrr_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int ID_W       = 32;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [ID_W-1:0]       task_id_t;
  typedef logic [SLOT_COUNT-1:0] slot_vec_t;

  // Request codes.
  localparam logic [1:0] REQ_CREATE   = 2'd0;
  localparam logic [1:0] REQ_DESTROY  = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;
  localparam logic [1:0] REQ_SCHEDULE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

endpackage

`default_nettype wire

[rtl/task_slot_table_round_robin.sv]
// ---------------------------------------------------------------------------
// Task slot table with round-robin picker
// Creates, destroys, dispatches and schedules tasks held in a slot table.
// ---------------------------------------------------------------------------
//  Channel  Ports    Payload (low bit first)
//  request  in_*     req_type[1:0], slot_sel[7:2]
//  result   out_*    status[1:0], result_slot[7:2], result_id[39:8],
//                    have_current[40], current_index[46:41], zero pad[47]
//
//  Create, destroy and dispatch read the task id memory on acceptance and
//  update the flags and the memory in the execute state. A schedule that
//  finds a ready slot reads the id memory port twice (start id, then id of
//  the picked slot), answering from the pick state, else from S_EXEC.
//  A request is taken only while the sequencer is idle; a result waiting in
//  the output register does not block the next request, only its completion.
//  rst_n clears the slot flags, the current pointer and sets the id counter
//  to one; the id memory itself is not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module task_slot_table_round_robin
  import tsrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // req_type[1:0], slot_sel[7:2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], result_slot[7:2], result_id[39:8], have_current[40],
  // current_index[46:41], zero[47]
  output logic [47:0]      out_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [1:0] req_r;
  slot_t      sel_r;
  slot_t      pick_r, pick_nxt;

  slot_vec_t  used_r, used_nxt;
  slot_vec_t  run_r, run_nxt;
  logic       cur_v_r, cur_v_nxt;
  slot_t      cur_s_r, cur_s_nxt;
  task_id_t   next_id_r, next_id_nxt;

  task_id_t   id_mem [SLOT_COUNT];
  task_id_t   rd_r;
  logic       mem_re, mem_we;
  slot_t      mem_addr;

  logic       out_valid_r;
  logic [47:0] out_data_r;
  logic       out_free;

  logic       emit;
  logic [1:0] e_status;
  slot_t      e_slot;
  task_id_t   e_id;

  logic       accept;
  logic [1:0] in_req;
  slot_t      in_sel;

  slot_vec_t  free_vec, ready_vec, rot_vec;
  logic [2*SLOT_COUNT-1:0] dbl_vec;
  logic       free_any, ready_any;
  slot_t      free_idx, ready_off, start_idx, pick_idx;

  assign in_req    = in_tdata[1:0];
  assign in_sel    = in_tdata[SLOT_W+1:2];
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Lowest free slot for create.
  assign free_vec = ~used_r;
  assign free_any = |free_vec;
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = slot_t'(i);
      end
    end
  end

  // Round-robin scan: rotate the ready flags so the start slot sits at bit
  // zero, take the lowest set bit and rotate the offset back.
  assign start_idx = rd_r[SLOT_W-1:0];
  assign ready_vec = used_r & ~run_r;
  assign ready_any = |ready_vec;
  assign dbl_vec   = {ready_vec, ready_vec} >> start_idx;
  assign rot_vec   = dbl_vec[SLOT_COUNT-1:0];
  always_comb begin
    ready_off = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (rot_vec[i]) begin
        ready_off = slot_t'(i);
      end
    end
  end
  assign pick_idx = start_idx + ready_off;

  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    run_nxt     = run_r;
    cur_v_nxt   = cur_v_r;
    cur_s_nxt   = cur_s_r;
    next_id_nxt = next_id_r;
    pick_nxt    = pick_r;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = sel_r;
    emit        = 1'b0;
    e_status    = ST_DONE;
    e_slot      = '0;
    e_id        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mem_re    = 1'b1;
          mem_addr  = (in_req == REQ_SCHEDULE) ? cur_s_r : in_sel;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (req_r)
          REQ_CREATE: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (free_any) begin
                mem_we             = 1'b1;
                mem_addr           = free_idx;
                used_nxt[free_idx] = 1'b1;
                run_nxt[free_idx]  = 1'b0;
                next_id_nxt        = next_id_r + 1'b1;
                e_slot             = free_idx;
                e_id               = next_id_r;
              end else begin
                e_status = ST_FULL;
              end
            end
          end
          REQ_DESTROY, REQ_DISPATCH: begin
            if (out_free) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (!used_r[sel_r]) begin
                e_status = ST_EMPTY;
              end else begin
                e_slot = sel_r;
                e_id   = rd_r;
                if (req_r == REQ_DESTROY) begin
                  used_nxt[sel_r] = 1'b0;
                  run_nxt[sel_r]  = 1'b0;
                  if (cur_v_r && cur_s_r == sel_r) begin
                    cur_v_nxt = 1'b0;
                  end
                end else begin
                  run_nxt[sel_r] = 1'b1;
                  cur_v_nxt      = 1'b1;
                  cur_s_nxt      = sel_r;
                end
              end
            end
          end
          REQ_SCHEDULE: begin
            if (!cur_v_r || !ready_any) begin
              if (out_free) begin
                emit      = 1'b1;
                e_status  = ST_NONE;
                state_nxt = S_IDLE;
              end
            end else begin
              // Fetch the id of the picked slot.
              mem_re    = 1'b1;
              mem_addr  = pick_idx;
              pick_nxt  = pick_idx;
              state_nxt = S_PICK;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_PICK: begin
        if (out_free) begin
          run_nxt[cur_s_r] = 1'b0;
          run_nxt[pick_r]  = 1'b1;
          cur_s_nxt        = pick_r;
          emit             = 1'b1;
          e_slot           = pick_r;
          e_id             = rd_r;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Task id memory, one read/write port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[mem_addr] <= next_id_r;
    end
    if (mem_re) begin
      rd_r <= id_mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      run_r       <= '0;
      cur_v_r     <= 1'b0;
      cur_s_r     <= '0;
      next_id_r   <= task_id_t'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      run_r     <= run_nxt;
      cur_v_r   <= cur_v_nxt;
      cur_s_r   <= cur_s_nxt;
      next_id_r <= next_id_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
      sel_r <= in_sel;
    end
    pick_r <= pick_nxt;
    if (emit) begin
      out_data_r <= {1'b0, (cur_v_nxt ? cur_s_nxt : slot_t'(0)), cur_v_nxt,
                     e_id, e_slot, e_status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The current task always sits in a used, running slot.
  a_cur_used: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> used_r[cur_s_r])
    else $error("current task slot is not in use");

  a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r |-> run_r[cur_s_r])
    else $error("current task slot is not running");

  a_run_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r & ~used_r) == '0)
    else $error("running flag set on a free slot");

  a_id_on_create: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(next_id_r)) |->
      $past(state_r == S_EXEC && req_r == REQ_CREATE))
    else $error("task id counter moved outside a create");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && e_status != ST_DONE) |-> (e_slot == '0 && e_id == '0))
    else $error("failed request reports a slot or id");

endmodule

`default_nettype wire

[verif/task_slot_table_checker.sv]
// ---------------------------------------------------------------------------
// Task slot table result checker
// Watches the request and result streams of the task slot table, keeps its
// own copy of the slot flags, task ids and current pointer, predicts the
// result of every accepted request and compares each returned result with
// the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module task_slot_table_checker
  import tsrr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,    // req_type[1:0], slot_sel[7:2]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  // status[1:0], result_slot[7:2], result_id[39:8], have_current[40],
  // current_index[46:41], zero[47]
  input  wire logic [47:0] out_tdata,
  output int               pending,
  output int               fail_count
);

  // Members run from the highest bit down, so status lands in the low bits.
  typedef struct packed {
    slot_t      cur_idx;
    logic       have_cur;
    task_id_t   id;
    slot_t      slot;
    logic [1:0] status;
  } sched_result_t;

  logic          used    [SLOT_COUNT];
  logic          running [SLOT_COUNT];
  task_id_t      task_ids[SLOT_COUNT];
  logic          cur_valid;
  slot_t         cur_slot;
  task_id_t      id_counter;
  sched_result_t awaited_results[$];

  // Applies one request to the shadow table and returns the result it causes.
  function automatic sched_result_t apply_request(logic [1:0] op, slot_t sel);
    sched_result_t r;
    task_id_t      start;
    int            idx;
    r = '0;
    case (op)
      REQ_CREATE: begin
        r.status = ST_FULL;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!used[i]) begin
            used[i]     = 1'b1;
            running[i]  = 1'b0;
            task_ids[i] = id_counter;
            r.status    = ST_DONE;
            r.slot      = slot_t'(i);
            r.id        = id_counter;
            id_counter  = id_counter + 1;
            break;
          end
        end
      end
      REQ_DESTROY, REQ_DISPATCH: begin
        if (int'(sel) >= SLOT_COUNT || !used[sel]) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_DONE;
          r.slot   = sel;
          r.id     = task_ids[sel];
          if (op == REQ_DESTROY) begin
            used[sel]    = 1'b0;
            running[sel] = 1'b0;
            if (cur_valid && cur_slot == sel) cur_valid = 1'b0;
          end else begin
            running[sel] = 1'b1;
            cur_valid    = 1'b1;
            cur_slot     = sel;
          end
        end
      end
      default: begin
        r.status = ST_NONE;
        if (cur_valid) begin
          // The scan starts at the current task id, not at the current slot.
          start = task_ids[cur_slot] % SLOT_COUNT;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            idx = int'((start + task_id_t'(i)) % SLOT_COUNT);
            if (used[idx] && !running[idx]) begin
              running[cur_slot] = 1'b0;
              running[idx]      = 1'b1;
              cur_slot          = slot_t'(idx);
              r.status          = ST_DONE;
              r.slot            = slot_t'(idx);
              r.id              = task_ids[idx];
              break;
            end
          end
        end
      end
    endcase
    r.have_cur = cur_valid;
    r.cur_idx  = cur_valid ? cur_slot : '0;
    return r;
  endfunction

  task automatic report_field(input string name, input longint unsigned want,
                              input longint unsigned got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    sched_result_t want;
    sched_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        used[i]     = 1'b0;
        running[i]  = 1'b0;
        task_ids[i] = '0;
      end
      cur_valid  = 1'b0;
      cur_slot   = '0;
      id_counter = 1;
      awaited_results.delete();
    end else begin
      // A result leaving at this edge always belongs to an older request.
      if (out_tvalid && out_tready) begin
        got = out_tdata[46:0];
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_field("status", want.status, got.status);
          if (got.slot !== want.slot)
            report_field("result_slot", want.slot, got.slot);
          if (got.id !== want.id)
            report_field("result_id", want.id, got.id);
          if (got.have_cur !== want.have_cur)
            report_field("have_current", want.have_cur, got.have_cur);
          if (got.cur_idx !== want.cur_idx)
            report_field("current_index", want.cur_idx, got.cur_idx);
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_request(in_tdata[1:0], in_tdata[7:2]));
    end
    pending <= awaited_results.size();
  end

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// Task slot table testbench
// Drives directed and random create, destroy, dispatch and schedule requests
// with random gaps and result back-pressure; the checker beside the block
// predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
  import tsrr_pkg::*;

  typedef enum int { MODE_FILL, MODE_CHURN, MODE_DRAIN } load_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;    // req_type[1:0], slot_sel[7:2]
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  // status[1:0], result_slot[7:2], result_id[39:8], have_current[40],
  // current_index[46:41], zero[47]
  logic [47:0] out_tdata;
  logic        calm       = 1'b0;
  int          pending;
  int          fail_count;

  task_slot_table_round_robin i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  task_slot_table_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 11);
  end

  // Leaves tvalid high across back-to-back requests.
  task automatic send_request(input logic [1:0] op, input slot_t sel);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sel, op};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [1:0] pick_request(load_mode_t mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:
        return roll < 55 ? REQ_CREATE : roll < 65 ? REQ_DESTROY :
               roll < 80 ? REQ_DISPATCH : REQ_SCHEDULE;
      MODE_DRAIN:
        return roll < 10 ? REQ_CREATE : roll < 65 ? REQ_DESTROY :
               roll < 80 ? REQ_DISPATCH : REQ_SCHEDULE;
      default:
        return roll < 25 ? REQ_CREATE : roll < 45 ? REQ_DESTROY :
               roll < 70 ? REQ_DISPATCH : REQ_SCHEDULE;
    endcase
  endfunction

  initial begin
    load_mode_t plan[13];
    load_mode_t mode;
    plan = '{MODE_FILL, MODE_FILL, MODE_CHURN, MODE_FILL, MODE_DRAIN, MODE_DRAIN,
             MODE_CHURN, MODE_FILL, MODE_FILL, MODE_FILL, MODE_FILL, MODE_CHURN,
             MODE_DRAIN};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing current, free slots named, then a small table walked through
    // dispatch, schedule and destroy of the current task.
    send_request(REQ_SCHEDULE, 6'd0);
    send_request(REQ_DESTROY, 6'd0);
    send_request(REQ_DISPATCH, 6'd63);
    send_request(REQ_CREATE, 6'd63);
    send_request(REQ_CREATE, 6'd0);
    send_request(REQ_CREATE, 6'd21);
    send_request(REQ_SCHEDULE, 6'd42);
    send_request(REQ_DISPATCH, 6'd1);
    send_request(REQ_DISPATCH, 6'd1);
    send_request(REQ_SCHEDULE, 6'd0);
    send_request(REQ_DISPATCH, 6'd0);
    send_request(REQ_SCHEDULE, 6'd63);
    send_request(REQ_DESTROY, 6'd1);
    send_request(REQ_SCHEDULE, 6'd0);
    send_request(REQ_DISPATCH, 6'd2);
    send_request(REQ_DISPATCH, 6'd0);
    send_request(REQ_SCHEDULE, 6'd0);
    send_request(REQ_DESTROY, 6'd2);
    send_request(REQ_CREATE, 6'd0);
    send_request(REQ_CREATE, 6'd0);
    send_request(REQ_SCHEDULE, 6'd0);
    send_request(REQ_DESTROY, 6'h3f);
    send_request(REQ_DISPATCH, 6'h2a);
    send_request(REQ_DESTROY, 6'h15);

    // Phases that fill the table until it is full, churn it and drain it.
    for (int n = 0; n < 750; n++) begin
      mode = plan[(n / 58) % 13];
      calm = (n >= 400 && n < 520);
      send_request(pick_request(mode),
                   $urandom_range(0, 1) ? slot_t'($urandom_range(0, 63))
                                        : slot_t'($urandom_range(0, 20)));
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
rtl/tsrr_pkg.sv
rtl/task_slot_table_round_robin.sv
verif/task_slot_table_checker.sv
verif/testbench.sv
